### rtl/ssc_pkg.sv
// Shared types and constants for the systolic schedule controller.
// No dependencies; every other file imports this package.
`default_nettype none

package ssc_pkg;

  localparam int unsigned LOOP_BITS    = 7;
  localparam int unsigned ARRAY_SIZE_W = 9;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned CFG_DATA_W   = 9;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ARRAY_SIZE   = 3'd0,
    CFG_FLOWS        = 3'd1,
    CFG_REPEATS      = 3'd2,
    CFG_TRANSPOSE    = 3'd3,
    CFG_REUSE        = 3'd4,
    CFG_FLOW_MODE    = 3'd5,
    CFG_SHIFT_ENABLE = 3'd6
  } cfg_index_t;

  // Mode codes that preset the operand input switch
  localparam logic [MODE_W-1:0] TRANSPOSE_SWITCH = 2'd2;
  localparam logic [MODE_W-1:0] TRANSPOSE_OFF    = 2'd0;
  localparam logic [MODE_W-1:0] REUSE_SWITCH     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OFF         = 2'd0;

  // Input switch codes
  localparam logic [1:0] SW_NONE = 2'b00;
  localparam logic [1:0] SW_BOTH = 2'b11;
  localparam logic [1:0] SW_LOW  = 2'b01;

  typedef struct packed {
    logic [ARRAY_SIZE_W-1:0] array_size;
    logic [LOOP_BITS-1:0]    flows_per_instruction;
    logic [LOOP_BITS-1:0]    instruction_repeats;
    logic [MODE_W-1:0]       transpose_mode;
    logic [MODE_W-1:0]       reuse_mode;
    logic [MODE_W-1:0]       flow_mode;
    logic                    shift_enable;
  } cfg_t;

  typedef struct packed {
    logic start_write;
    logic load_complete;
    logic preload_complete;
    logic update_complete;
    logic write_finished;
    logic last_flow_time_clear;
  } tick_t;

  typedef struct packed {
    logic [2:0]           core_phase;
    logic [1:0]           instruction_phase;
    logic [1:0]           operand_switch;
    logic                 execute_start;
    logic                 flow_end;
    logic                 last_flow_time;
    logic                 last_instruction;
    logic                 last_instruction_time;
    logic                 instruction_done;
    logic [LOOP_BITS-1:0] flow_count;
    logic [LOOP_BITS-1:0] instruction_count;
  } result_t;

endpackage

`default_nettype wire

### rtl/ssc_tick_if.sv
// Request channel carrying one controller tick.
// Depends on ssc_pkg for the tick payload type.
`default_nettype none

interface ssc_tick_if import ssc_pkg::*; ();
  logic  valid;
  logic  ready;
  tick_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ssc_result_if.sv
// Result channel carrying the controller state after one tick.
// Depends on ssc_pkg for the result payload type.
`default_nettype none

interface ssc_result_if import ssc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ssc_cfg.sv
// Configuration register file of the schedule controller.
// Depends on ssc_pkg for the register indexes and cfg_t.
`default_nettype none

module ssc_cfg import ssc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.array_size            <= 9'd32;
      cfg.flows_per_instruction <= 7'd1;
      cfg.instruction_repeats   <= 7'd1;
      cfg.transpose_mode        <= 2'd0;
      cfg.reuse_mode            <= 2'd0;
      cfg.flow_mode             <= 2'd0;
      cfg.shift_enable          <= 1'b0;
    end else if (cfg_we) begin
      // unknown indexes drop silently
      case (cfg_index)
        CFG_ARRAY_SIZE:   cfg.array_size            <= cfg_data[ARRAY_SIZE_W-1:0];
        CFG_FLOWS:        cfg.flows_per_instruction <= cfg_data[LOOP_BITS-1:0];
        CFG_REPEATS:      cfg.instruction_repeats   <= cfg_data[LOOP_BITS-1:0];
        CFG_TRANSPOSE:    cfg.transpose_mode        <= cfg_data[MODE_W-1:0];
        CFG_REUSE:        cfg.reuse_mode            <= cfg_data[MODE_W-1:0];
        CFG_FLOW_MODE:    cfg.flow_mode             <= cfg_data[MODE_W-1:0];
        CFG_SHIFT_ENABLE: cfg.shift_enable          <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/ssc_sched.sv
// Phase machines, loop counters and flags of the schedule controller.
// Depends on ssc_pkg; advances one tick per accepted request.
`default_nettype none

module ssc_sched import ssc_pkg::*; #(
  parameter int unsigned ARRAY_COUNT_BITS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  advance,
  input  wire tick_t tick,
  input  wire cfg_t  cfg,
  output result_t    res_next
);

  localparam int unsigned CMP_W =
    (ARRAY_COUNT_BITS > ARRAY_SIZE_W) ? ARRAY_COUNT_BITS : ARRAY_SIZE_W;

  typedef enum logic [2:0] {
    CP_IDLE, CP_REG_LOAD, CP_TRANS_LOAD, CP_CLIP,
    CP_FIRST_LOAD, CP_REUSE, CP_OUT, CP_UNLOAD
  } core_t;

  typedef enum logic [1:0] {IP_IDLE, IP_FIRST, IP_LOOP, IP_DONE} instr_t;

  core_t                       core, core_next;
  instr_t                      ip, ip_next;
  logic [1:0]                  switch_bits, switch_bits_next;
  logic                        start_flag, start_flag_next;
  logic                        start_delayed;
  logic                        load_delayed;
  logic [ARRAY_COUNT_BITS-1:0] transpose_count, transpose_count_next;
  logic                        update_seen, update_seen_next;
  logic [LOOP_BITS-1:0]        instr_count, instr_count_next;
  logic                        last_instr_time, last_instr_time_next;
  logic [LOOP_BITS-1:0]        flow_count, flow_count_next;
  logic                        last_flow, last_flow_next;
  logic                        flow_clear_delayed;
  logic                        last_instr, last_instr_next;
  logic                        exec_start;

  logic                        trans_flag, keep_mode, conv_mode;
  logic [LOOP_BITS-1:0]        flows_m1, reps_m1, flow_limit;
  logic                        trans_clear, flow_clear, instr_clear;
  logic                        cond_a, dout_cond, in_out, keep_done;
  logic                        trans_exec, next_exec, last_instr_set, flow_end;

  always_comb begin
    trans_flag = cfg.transpose_mode != TRANSPOSE_OFF;
    keep_mode  = cfg.flow_mode[1];
    conv_mode  = (cfg.reuse_mode != MODE_OFF) && (switch_bits[0] ^ switch_bits[1]);
    flows_m1   = cfg.flows_per_instruction - LOOP_BITS'(1);
    reps_m1    = cfg.instruction_repeats - LOOP_BITS'(1);
    flow_limit = (ip == IP_FIRST) ? cfg.flows_per_instruction : flows_m1;
    trans_clear = (cfg.array_size != '0) &&
                  (CMP_W'(transpose_count) == CMP_W'(cfg.array_size - ARRAY_SIZE_W'(1)));
    flow_clear  = (flow_count == flow_limit) && tick.load_complete;
    instr_clear = (instr_count == reps_m1) && flow_clear;

    cond_a = last_instr ? tick.update_complete
           : (!cfg.shift_enable && !keep_mode && (tick.update_complete || update_seen));
    dout_cond = cond_a || tick.update_complete || tick.write_finished;
    in_out    = core == CP_OUT;
    keep_done = keep_mode && in_out && (ip == IP_DONE) && dout_cond;

    ip_next = ip;
    unique case (ip)
      IP_IDLE:  if (start_delayed) ip_next = IP_FIRST;
      IP_FIRST: begin
        if (instr_clear) ip_next = IP_DONE;
        else if (dout_cond && in_out) ip_next = IP_LOOP;
      end
      IP_LOOP:  if (instr_clear) ip_next = IP_DONE;
      IP_DONE:  if (dout_cond && in_out) ip_next = IP_IDLE;
    endcase

    // transpose modes with bit 0 set (1 and 3) start the first instruction from the transpose load
    trans_exec = (cfg.transpose_mode[0] && instr_count == '0)
               ? (trans_clear && core == CP_TRANS_LOAD) : (dout_cond && in_out);
    next_exec  = (ip == IP_FIRST || ip == IP_LOOP) && trans_exec;
    last_instr_set = in_out && (instr_count == reps_m1) &&
      ((ip == IP_LOOP) ||
       (ip == IP_DONE && cfg.instruction_repeats == LOOP_BITS'(1)) ||
       (ip == IP_FIRST && cfg.instruction_repeats > LOOP_BITS'(1) && dout_cond));

    core_next = core;
    flow_end  = 1'b0;
    unique case (core)
      CP_IDLE: begin
        if (start_delayed) core_next = CP_REG_LOAD;
        else if (ip == IP_LOOP) core_next = CP_REUSE;
      end
      CP_REG_LOAD: begin
        if (tick.preload_complete) core_next = trans_flag ? CP_TRANS_LOAD : CP_REUSE;
      end
      CP_TRANS_LOAD: begin
        if (trans_clear || tick.load_complete) core_next = CP_REUSE;
      end
      CP_CLIP, CP_FIRST_LOAD: begin
        if (flow_clear) core_next = CP_OUT;
        else if (conv_mode && tick.load_complete) core_next = CP_REUSE;
      end
      CP_REUSE: begin
        if (flow_clear) begin
          core_next = CP_OUT;
        end else if (flow_count == flow_limit - LOOP_BITS'(1) &&
                     tick.load_complete && trans_flag) begin
          core_next = (cfg.instruction_repeats == LOOP_BITS'(1) || instr_count == reps_m1)
                    ? CP_FIRST_LOAD : CP_CLIP;
        end
      end
      CP_OUT: begin
        priority if (ip == IP_DONE && dout_cond) begin
          if (keep_mode) begin
            core_next = CP_IDLE;
            flow_end  = 1'b1;
          end else begin
            core_next = CP_UNLOAD;
          end
        end else if (ip == IP_FIRST && !instr_clear && dout_cond) begin
          core_next = CP_REUSE;
        end else if (ip == IP_LOOP && dout_cond) begin
          core_next = CP_REUSE;
        end
      end
      CP_UNLOAD: begin
        if (tick.write_finished) begin
          core_next = CP_IDLE;
          flow_end  = 1'b1;
        end
      end
    endcase

    switch_bits_next = switch_bits;
    unique case (core)
      CP_IDLE: begin
        switch_bits_next = (cfg.transpose_mode == TRANSPOSE_SWITCH ||
                            (cfg.transpose_mode == TRANSPOSE_OFF &&
                             cfg.reuse_mode == REUSE_SWITCH)) ? SW_BOTH : SW_NONE;
      end
      CP_FIRST_LOAD, CP_REG_LOAD: begin
        // toggle the low switch bit one tick after a load completes
        if (load_delayed && !conv_mode)
          switch_bits_next = {switch_bits[1], ~switch_bits[0]};
      end
      CP_REUSE:  switch_bits_next = SW_LOW;
      CP_OUT:    if (flow_end) switch_bits_next = SW_NONE;
      CP_UNLOAD: switch_bits_next = SW_NONE;
      CP_TRANS_LOAD, CP_CLIP: ;
    endcase

    // clear wins over set on every flag
    start_flag_next = (start_flag || flow_end) ? 1'b0
                    : (tick.start_write ? 1'b1 : start_flag);
    transpose_count_next = trans_clear ? '0
      : ((core == CP_TRANS_LOAD) ? transpose_count + ARRAY_COUNT_BITS'(1) : transpose_count);
    update_seen_next = flow_end ? 1'b0 : (tick.update_complete || update_seen);
    instr_count_next = instr_clear ? '0
      : (flow_clear ? instr_count + LOOP_BITS'(1) : instr_count);
    last_instr_time_next = tick.last_flow_time_clear ? 1'b0
                         : (instr_clear || last_instr_time);
    flow_count_next = flow_clear ? '0
      : ((tick.load_complete && !last_instr_time) ? flow_count + LOOP_BITS'(1) : flow_count);
    last_flow_next = (exec_start || flow_end) ? 1'b0 : (flow_clear_delayed || last_flow);
    last_instr_next = (tick.write_finished || keep_done) ? 1'b0
                    : (last_instr_set || last_instr);

    res_next.core_phase            = core_next;
    res_next.instruction_phase     = ip_next;
    res_next.operand_switch        = switch_bits_next;
    res_next.execute_start         = next_exec;
    res_next.flow_end              = flow_end;
    res_next.last_flow_time        = last_flow_next;
    res_next.last_instruction      = last_instr_next;
    res_next.last_instruction_time = last_instr_time_next;
    res_next.instruction_done      = instr_clear;
    res_next.flow_count            = flow_count_next;
    res_next.instruction_count     = instr_count_next;
  end

  // the instruction-clear and flow-end pulses live in the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      core               <= CP_IDLE;
      ip                 <= IP_IDLE;
      switch_bits        <= SW_NONE;
      start_flag         <= 1'b0;
      start_delayed      <= 1'b0;
      load_delayed       <= 1'b0;
      transpose_count    <= '0;
      update_seen        <= 1'b0;
      instr_count        <= '0;
      last_instr_time    <= 1'b0;
      flow_count         <= '0;
      last_flow          <= 1'b0;
      flow_clear_delayed <= 1'b0;
      last_instr         <= 1'b0;
      exec_start         <= 1'b0;
    end else if (advance) begin
      core               <= core_next;
      ip                 <= ip_next;
      switch_bits        <= switch_bits_next;
      start_flag         <= start_flag_next;
      start_delayed      <= start_flag;
      load_delayed       <= tick.load_complete;
      transpose_count    <= transpose_count_next;
      update_seen        <= update_seen_next;
      instr_count        <= instr_count_next;
      last_instr_time    <= last_instr_time_next;
      flow_count         <= flow_count_next;
      last_flow          <= last_flow_next;
      flow_clear_delayed <= flow_clear;
      last_instr         <= last_instr_next;
      exec_start         <= next_exec;
    end
  end

endmodule

`default_nettype wire

### rtl/systolic_schedule_controller_core.sv
// Top level of the systolic schedule controller: config registers, scheduler
// and the result register. Depends on ssc_pkg, ssc_tick_if, ssc_result_if, ssc_cfg and ssc_sched.
//
// Every request is one controller tick. The phase machines and counters update
// at the accepting edge, and the state after the tick lands in the result
// register at the same edge, so a result is offered in the cycle after its
// request. A request can be accepted every cycle; ready drops only while the
// result register holds a result that the sink has not taken. Configuration
// writes take effect at the next edge; the user must keep them to idle
// periods, as the block does not enforce it.
`default_nettype none

module systolic_schedule_controller_core import ssc_pkg::*; #(
  parameter int unsigned ARRAY_COUNT_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  ssc_tick_if.sink                    cmd,
  ssc_result_if.source                res,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  result_t res_next;
  result_t res_data;
  logic    res_valid;
  logic    advance;

  assign cmd.ready = !res_valid || res.ready;
  assign advance   = cmd.valid && cmd.ready;

  ssc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssc_sched #(
    .ARRAY_COUNT_BITS (ARRAY_COUNT_BITS)
  ) u_sched (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .tick     (cmd.data),
    .cfg      (cfg),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // payload holds until the next accepted request
  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= res_next;
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_data;

endmodule

`default_nettype wire

### test/ssc_schedule_checker.sv
// Scoreboard for the systolic schedule controller: watches the tick, result and
// register-write ports, predicts the state after every tick and compares it.
// Depends on ssc_pkg for the tick, result and register types.
module ssc_schedule_checker import ssc_pkg::*; #(
  parameter int unsigned ARRAY_COUNT_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick_valid,
  input  logic                   tick_ready,
  input  tick_t                  tick_data,
  input  logic                   res_valid,
  input  logic                   res_ready,
  input  result_t                res_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     pending,
  output int                     errors,
  output logic [7:0]             phases_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    CORE_IDLE, CORE_REG_LOAD, CORE_TRANS_LOAD, CORE_CLIP,
    CORE_FIRST_LOAD, CORE_REUSE, CORE_OUT, CORE_UNLOAD
  } core_phase_e;

  typedef enum logic [1:0] {
    INSTR_IDLE, INSTR_FIRST, INSTR_LOOP, INSTR_DONE
  } instr_phase_e;

  cfg_t                        settings;
  core_phase_e                 core_q;
  instr_phase_e                instr_q;
  logic [1:0]                  switch_q;
  logic                        start_q, start_d, load_d, update_seen_q;
  logic [ARRAY_COUNT_BITS-1:0] transpose_cnt;
  logic [LOOP_BITS-1:0]        instr_cnt, flow_cnt;
  logic                        last_instr_time_q, last_flow_q, last_instr_q;
  logic                        flow_clear_d, exec_start_d, instr_clear_d, flow_end_d;

  result_t predicted_states[$];
  int      result_idx;

  task automatic report(input string what);
    if (errors < 40) $display("%0t ns result %0d: %s", $time, result_idx, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // One controller tick: every guard reads the state before the edge.
  task automatic advance_schedule(input tick_t t, output result_t r);
    logic                 trans_on, keep_mode, exec_flag, conv_mode;
    logic                 trans_clear, flow_clear, instr_clear;
    logic                 out_cond, dout, in_out, keep_done;
    logic                 trans_exec, next_exec, last_instr, flow_end, old_start, old_lit;
    logic [LOOP_BITS-1:0] flows_m1, reps_m1, flow_limit, flow_limit_m1;
    core_phase_e          next_core;
    instr_phase_e         next_instr;
    logic [1:0]           next_sw;

    trans_on  = settings.transpose_mode != TRANSPOSE_OFF;
    keep_mode = settings.flow_mode[1];
    exec_flag = switch_q[0] ^ switch_q[1];
    conv_mode = (settings.reuse_mode != MODE_OFF) && exec_flag;

    flows_m1      = settings.flows_per_instruction - 1'b1;
    reps_m1       = settings.instruction_repeats - 1'b1;
    flow_limit    = (instr_q == INSTR_FIRST) ? settings.flows_per_instruction : flows_m1;
    flow_limit_m1 = flow_limit - 1'b1;
    // compare at full width so an unreachable size never clears the counter
    trans_clear = (settings.array_size != 0) &&
                  (int'(transpose_cnt) == int'(settings.array_size) - 1);
    flow_clear  = (flow_cnt == flow_limit) && t.load_complete;
    instr_clear = (instr_cnt == reps_m1) && flow_clear;

    out_cond  = last_instr_q ? t.update_complete :
                (!settings.shift_enable && !keep_mode &&
                 (t.update_complete || update_seen_q));
    dout      = out_cond || t.update_complete || t.write_finished;
    in_out    = core_q == CORE_OUT;
    keep_done = keep_mode && in_out && instr_q == INSTR_DONE && dout;

    next_instr = instr_q;
    case (instr_q)
      INSTR_IDLE:  if (start_d) next_instr = INSTR_FIRST;
      INSTR_FIRST: begin
        if (instr_clear) next_instr = INSTR_DONE;
        else if (dout && in_out) next_instr = INSTR_LOOP;
      end
      INSTR_LOOP:  if (instr_clear) next_instr = INSTR_DONE;
      default:     if (dout && in_out) next_instr = INSTR_IDLE;
    endcase

    trans_exec = (settings.transpose_mode[0] && instr_cnt == 0) ?
                 (trans_clear && core_q == CORE_TRANS_LOAD) : (dout && in_out);
    next_exec  = (instr_q == INSTR_FIRST || instr_q == INSTR_LOOP) && trans_exec;
    last_instr = in_out && instr_cnt == reps_m1 &&
                 (instr_q == INSTR_LOOP ||
                  (instr_q == INSTR_DONE && settings.instruction_repeats == 1) ||
                  (instr_q == INSTR_FIRST && settings.instruction_repeats > 1 && dout));

    next_core = core_q;
    flow_end  = 1'b0;
    case (core_q)
      CORE_IDLE: begin
        if (start_d) next_core = CORE_REG_LOAD;
        else if (instr_q == INSTR_LOOP) next_core = CORE_REUSE;
      end
      CORE_REG_LOAD: begin
        if (t.preload_complete) next_core = trans_on ? CORE_TRANS_LOAD : CORE_REUSE;
      end
      CORE_TRANS_LOAD: if (trans_clear || t.load_complete) next_core = CORE_REUSE;
      CORE_CLIP, CORE_FIRST_LOAD: begin
        if (flow_clear) next_core = CORE_OUT;
        else if (conv_mode && t.load_complete) next_core = CORE_REUSE;
      end
      CORE_REUSE: begin
        if (flow_clear) begin
          next_core = CORE_OUT;
        end else if (flow_cnt == flow_limit_m1 && t.load_complete && trans_on) begin
          next_core = (settings.instruction_repeats == 1 || instr_cnt == reps_m1) ?
                      CORE_FIRST_LOAD : CORE_CLIP;
        end
      end
      CORE_OUT: begin
        if (instr_q == INSTR_DONE && dout) begin
          if (keep_mode) begin
            next_core = CORE_IDLE;
            flow_end  = 1'b1;
          end else begin
            next_core = CORE_UNLOAD;
          end
        end else if (instr_q == INSTR_FIRST && !instr_clear && dout) begin
          next_core = CORE_REUSE;
        end else if (instr_q == INSTR_LOOP && dout) begin
          next_core = CORE_REUSE;
        end
      end
      default: begin
        if (t.write_finished) begin
          next_core = CORE_IDLE;
          flow_end  = 1'b1;
        end
      end
    endcase

    next_sw = switch_q;
    case (core_q)
      CORE_IDLE: begin
        next_sw = (settings.transpose_mode == TRANSPOSE_SWITCH ||
                   (settings.transpose_mode == TRANSPOSE_OFF &&
                    settings.reuse_mode == REUSE_SWITCH)) ? SW_BOTH : SW_NONE;
      end
      CORE_FIRST_LOAD, CORE_REG_LOAD: begin
        if (load_d && !conv_mode) next_sw = {switch_q[1], ~switch_q[0]};
      end
      CORE_REUSE:  next_sw = SW_LOW;
      CORE_OUT:    if (flow_end) next_sw = SW_NONE;
      CORE_UNLOAD: next_sw = SW_NONE;
      default: ;
    endcase

    // commit: a clear wins over a set
    old_start = start_q;
    old_lit   = last_instr_time_q;
    if (start_q || flow_end) start_q = 1'b0;
    else if (t.start_write) start_q = 1'b1;
    start_d = old_start;
    load_d  = t.load_complete;
    if (trans_clear) transpose_cnt = '0;
    else if (core_q == CORE_TRANS_LOAD) transpose_cnt = transpose_cnt + 1'b1;
    if (flow_end) update_seen_q = 1'b0;
    else if (t.update_complete) update_seen_q = 1'b1;
    if (instr_clear) instr_cnt = '0;
    else if (flow_clear) instr_cnt = instr_cnt + 1'b1;
    if (t.last_flow_time_clear) last_instr_time_q = 1'b0;
    else if (instr_clear) last_instr_time_q = 1'b1;
    if (flow_clear) flow_cnt = '0;
    else if (t.load_complete && !old_lit) flow_cnt = flow_cnt + 1'b1;
    if (exec_start_d || flow_end) last_flow_q = 1'b0;
    else if (flow_clear_d) last_flow_q = 1'b1;
    if (t.write_finished || keep_done) last_instr_q = 1'b0;
    else if (last_instr) last_instr_q = 1'b1;

    instr_q       = next_instr;
    core_q        = next_core;
    switch_q      = next_sw;
    exec_start_d  = next_exec;
    flow_clear_d  = flow_clear;
    instr_clear_d = instr_clear;
    flow_end_d    = flow_end;

    r.core_phase            = core_q;
    r.instruction_phase     = instr_q;
    r.operand_switch        = switch_q;
    r.execute_start         = exec_start_d;
    r.flow_end              = flow_end_d;
    r.last_flow_time        = last_flow_q;
    r.last_instruction      = last_instr_q;
    r.last_instruction_time = last_instr_time_q;
    r.instruction_done      = instr_clear_d;
    r.flow_count            = flow_cnt;
    r.instruction_count     = instr_cnt;
  endtask

  always @(posedge clk) begin
    result_t want, next_state;
    if (rst) begin
      settings.array_size            = 9'd32;
      settings.flows_per_instruction = 7'd1;
      settings.instruction_repeats   = 7'd1;
      settings.transpose_mode        = TRANSPOSE_OFF;
      settings.reuse_mode            = MODE_OFF;
      settings.flow_mode             = MODE_OFF;
      settings.shift_enable          = 1'b0;
      core_q            = CORE_IDLE;
      instr_q           = INSTR_IDLE;
      switch_q          = SW_NONE;
      start_q           = 1'b0;
      start_d           = 1'b0;
      load_d            = 1'b0;
      update_seen_q     = 1'b0;
      transpose_cnt     = '0;
      instr_cnt         = '0;
      flow_cnt          = '0;
      last_instr_time_q = 1'b0;
      last_flow_q       = 1'b0;
      last_instr_q      = 1'b0;
      flow_clear_d      = 1'b0;
      exec_start_d      = 1'b0;
      instr_clear_d     = 1'b0;
      flow_end_d        = 1'b0;
      predicted_states.delete();
      result_idx  = 0;
      errors      = 0;
      phases_seen = '0;
      pending <= 0;
    end else begin
      // a result never leaves in the cycle its request arrives, so pop first
      if (res_valid && res_ready) begin
        if (predicted_states.size() == 0) begin
          report("result with no request waiting");
        end else begin
          want = predicted_states.pop_front();
          check_field("core_phase", res_data.core_phase, want.core_phase);
          check_field("instruction_phase", res_data.instruction_phase,
                      want.instruction_phase);
          check_field("operand_switch", res_data.operand_switch, want.operand_switch);
          check_field("execute_start", res_data.execute_start, want.execute_start);
          check_field("flow_end", res_data.flow_end, want.flow_end);
          check_field("last_flow_time", res_data.last_flow_time, want.last_flow_time);
          check_field("last_instruction", res_data.last_instruction,
                      want.last_instruction);
          check_field("last_instruction_time", res_data.last_instruction_time,
                      want.last_instruction_time);
          check_field("instruction_done", res_data.instruction_done,
                      want.instruction_done);
          check_field("flow_count", res_data.flow_count, want.flow_count);
          check_field("instruction_count", res_data.instruction_count,
                      want.instruction_count);
        end
        phases_seen[res_data.core_phase] = 1'b1;
        result_idx++;
      end
      if (tick_valid && tick_ready) begin
        advance_schedule(tick_data, next_state);
        predicted_states.push_back(next_state);
      end
      // a write lands at this edge and governs later ticks only
      if (cfg_we) begin
        case (cfg_index)
          CFG_ARRAY_SIZE:   settings.array_size            = cfg_data[ARRAY_SIZE_W-1:0];
          CFG_FLOWS:        settings.flows_per_instruction = cfg_data[LOOP_BITS-1:0];
          CFG_REPEATS:      settings.instruction_repeats   = cfg_data[LOOP_BITS-1:0];
          CFG_TRANSPOSE:    settings.transpose_mode        = cfg_data[MODE_W-1:0];
          CFG_REUSE:        settings.reuse_mode            = cfg_data[MODE_W-1:0];
          CFG_FLOW_MODE:    settings.flow_mode             = cfg_data[MODE_W-1:0];
          CFG_SHIFT_ENABLE: settings.shift_enable          = cfg_data[0];
          default: ;
        endcase
      end
      pending <= predicted_states.size();
    end
  end

endmodule

### test/testbench.sv
// Top of the schedule controller testbench: clock, reset, register settings,
// tick stimulus with sender gaps and receiver stalls, and the verdict.
// Depends on ssc_pkg, the two channel interfaces, the core and the checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ssc_pkg::*;

  localparam logic [5:0] TK_NONE   = 6'b000000;
  localparam logic [5:0] TK_ALL    = 6'b111111;
  localparam logic [5:0] TK_START  = 6'b100000;
  localparam logic [5:0] TK_LOAD   = 6'b010000;
  localparam logic [5:0] TK_REG    = 6'b001000;
  localparam logic [5:0] TK_UPDATE = 6'b000100;
  localparam logic [5:0] TK_WRITE  = 6'b000010;
  localparam logic [5:0] TK_CLEAR  = 6'b000001;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_TICKS   = 85;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     pending, errors;
  logic [7:0]             phases_seen;
  int                     ticks_sent = 0;
  int                     settings_used = 0;
  int                     burst_left = 1;
  rx_mode_e               rx_mode = RX_OPEN;
  int                     rx_left = 0;
  int                     rx_count = 0;

  logic [5:0] directed_ticks [20] = '{
    TK_NONE, TK_ALL, TK_START, TK_LOAD, TK_REG, TK_UPDATE, TK_WRITE, TK_CLEAR,
    TK_START, TK_NONE, TK_NONE, TK_REG, TK_LOAD, TK_LOAD | TK_UPDATE, TK_LOAD,
    TK_UPDATE, TK_WRITE, TK_WRITE, TK_CLEAR, TK_LOAD | TK_CLEAR
  };

  ssc_tick_if   tick_ch ();
  ssc_result_if res_ch ();

  systolic_schedule_controller_core uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (tick_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ssc_schedule_checker sched_check (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick_ch.valid),
    .tick_ready  (tick_ch.ready),
    .tick_data   (tick_ch.data),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .res_data    (res_ch.data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pending     (pending),
    .errors      (errors),
    .phases_seen (phases_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stretches of open, coin-flip, sparse and periodic acceptance
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 64);
      end
      rx_left--;
      rx_count++;
      case (rx_mode)
        RX_OPEN:   res_ch.ready <= 1'b1;
        RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   res_ch.ready <= (rx_count % 3) != 0;
      endcase
    end
  end

  function automatic cfg_t make_settings(input int size, input int flows, input int reps,
                                         input int tmode, input int rmode, input int fmode,
                                         input int shift);
    cfg_t c;
    c.array_size            = ARRAY_SIZE_W'(size);
    c.flows_per_instruction = LOOP_BITS'(flows);
    c.instruction_repeats   = LOOP_BITS'(reps);
    c.transpose_mode        = MODE_W'(tmode);
    c.reuse_mode            = MODE_W'(rmode);
    c.flow_mode             = MODE_W'(fmode);
    c.shift_enable          = 1'(shift);
    return c;
  endfunction

  // Protocol-shaped tick: loads common, finishes and clears now and then
  function automatic tick_t stream_tick();
    tick_t t;
    t.start_write          = ($urandom_range(0, 31) == 0);
    t.load_complete        = 1'($urandom_range(0, 1));
    t.preload_complete     = ($urandom_range(0, 3) == 0);
    t.update_complete      = ($urandom_range(0, 5) == 0);
    t.write_finished       = ($urandom_range(0, 7) == 0);
    t.last_flow_time_clear = ($urandom_range(0, 5) == 0);
    return t;
  endfunction

  // Offer one request, hold it until taken, then perhaps open a gap
  task automatic offer(input tick_t t);
    int gap;
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= t;
    do @(posedge clk); while (!tick_ch.ready);
    ticks_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Hold off new requests until every result has come back
  task automatic drain();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Junk in the upper data bits must be masked off by the block
  task automatic apply_settings(input cfg_t c);
    write_reg(CFG_ARRAY_SIZE, c.array_size);
    write_reg(CFG_FLOWS, {2'($urandom), c.flows_per_instruction});
    write_reg(CFG_REPEATS, {2'($urandom), c.instruction_repeats});
    write_reg(CFG_TRANSPOSE, {7'($urandom), c.transpose_mode});
    write_reg(CFG_REUSE, {7'($urandom), c.reuse_mode});
    write_reg(CFG_FLOW_MODE, {7'($urandom), c.flow_mode});
    write_reg(CFG_SHIFT_ENABLE, {8'($urandom), c.shift_enable});
    write_reg(CFG_SPARE_INDEX, 9'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(input int count);
    int sent, len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) != 0) begin
        // a command: start pulse, then a stream of loads and finishes
        len = $urandom_range(8, 60);
        offer(stream_tick() | TK_START);
        repeat (len) offer(stream_tick());
        sent += len + 1;
      end else begin
        len = $urandom_range(1, 12);
        repeat (len) offer(6'($urandom));
        sent += len;
      end
    end
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    tick_ch.valid  <= 1'b0;
    tick_ch.data   <= TK_NONE;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    apply_settings(make_settings(32, 1, 1, 0, 0, 0, 0));
    foreach (directed_ticks[i]) offer(directed_ticks[i]);
    drain();

    apply_settings(make_settings(1, 1, 1, 1, 0, 0, 0));
    run_random(PHASE_TICKS);
    drain();
    apply_settings(make_settings(4, 3, 2, 3, 1, 2, 0));
    run_random(PHASE_TICKS);
    drain();
    // a zero repeat count acts as a full-width terminal count; a zero array size never clears the transpose counter
    apply_settings(make_settings(0, 0, 0, 2, 2, 3, 1));
    run_random(PHASE_TICKS);
    drain();
    apply_settings(make_settings(256, 127, 127, 1, 3, 0, 0));
    run_random(PHASE_TICKS);
    drain();
    // array size beyond the counter range: transpose counter only wraps
    apply_settings(make_settings(511, 2, 3, 0, 2, 1, 1));
    run_random(PHASE_TICKS);
    drain();
    apply_settings(make_settings(2, 1, 4, 1, 1, 0, 0));
    run_random(PHASE_TICKS);
    drain();
    repeat (RANDOM_PHASES) begin
      apply_settings(make_settings($urandom_range(1, 8), $urandom_range(1, 4),
                                   $urandom_range(1, 4), $urandom_range(0, 3),
                                   $urandom_range(0, 3), $urandom_range(0, 3),
                                   $urandom_range(0, 1)));
      run_random(PHASE_TICKS);
      drain();
    end

    repeat (4) @(posedge clk);
    $display("run: %0d ticks under %0d register settings", ticks_sent, settings_used);
    $display("run: core phases reached (bit per phase) %b", phases_seen);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
